// ----- rtl/core/ltsc_pkg.sv -----
// ----------------------------------------------------------------------------
// ltsc_pkg
// Shared types and constants of the light triggered spray controller.
// ----------------------------------------------------------------------------
package ltsc_pkg;

	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_READY_WAIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_HOLD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_BEEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_READY_BEEP  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_OFF   = 3'd6;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_WAIT    = 3'd1;
	localparam logic [2:0] ST_READY   = 3'd2;
	localparam logic [2:0] ST_SPRAY   = 3'd3;
	localparam logic [2:0] ST_BLOCKED = 3'd4;
	localparam logic [2:0] ST_BEEP    = 3'd5;

	// session flag bit positions
	localparam int unsigned F_AUTO     = 0;
	localparam int unsigned F_SPRAYED  = 1;
	localparam int unsigned F_HOLD     = 2;
	localparam int unsigned F_CANCEL   = 3;
	localparam int unsigned F_BTNSPRAY = 4;
	localparam int unsigned F_BLINK    = 5;

	// LED latch codes, red in bit 0
	localparam logic [2:0] LED_OFF = 3'b000;
	localparam logic [2:0] LED_R   = 3'b001;
	localparam logic [2:0] LED_G   = 3'b010;
	localparam logic [2:0] LED_B   = 3'b100;

	typedef struct packed {
		logic [15:0] ready_wait_ms;
		logic [23:0] lockout_ms;
		logic [15:0] reset_hold_ms;
		logic [15:0] reset_beep_ms;
		logic [15:0] ready_tone_ms;
		logic [15:0] blink_on_ms;
		logic [15:0] blink_off_ms;
	} cfg_t;

	typedef struct packed {
		logic       spray_finished;
		logic       button_down;
		logic       spray_after_off;
		logic       light_present;
		logic [1:0] spray_mode;
	} item_in_t;

	typedef struct packed {
		logic       spray_run;
		logic       buzzer_on;
		logic       led_blue;
		logic       led_green;
		logic       led_red;
		logic [2:0] fsm_state;
	} item_out_t;

endpackage

// ----- rtl/core/ltsc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ltsc_cfg_regs
// Timing register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module ltsc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [ltsc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [23:0]                     wr_data,
	output ltsc_pkg::cfg_t                  cfg
);
	import ltsc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ready_wait_ms <= 16'd5000;
			cfg_q.lockout_ms    <= 24'd600000;
			cfg_q.reset_hold_ms <= 16'd3000;
			cfg_q.reset_beep_ms <= 16'd500;
			cfg_q.ready_tone_ms <= 16'd200;
			cfg_q.blink_on_ms   <= 16'd100;
			cfg_q.blink_off_ms  <= 16'd900;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_READY_WAIT: cfg_q.ready_wait_ms <= wr_data[15:0];
				REG_BLOCK:      cfg_q.lockout_ms    <= wr_data;
				REG_RESET_HOLD: cfg_q.reset_hold_ms <= wr_data[15:0];
				REG_RESET_BEEP: cfg_q.reset_beep_ms <= wr_data[15:0];
				REG_READY_BEEP: cfg_q.ready_tone_ms <= wr_data[15:0];
				REG_BLINK_ON:   cfg_q.blink_on_ms   <= wr_data[15:0];
				REG_BLINK_OFF:  cfg_q.blink_off_ms  <= wr_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/ltsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ltsc_ctrl
// Per-tick control state machine: timestamps, session flags, LED latch,
// ready beep counter. Each item enabled by item_en updates the state.
// ----------------------------------------------------------------------------
module ltsc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ltsc_pkg::cfg_t        cfg,
	input  logic                  item_en,
	input  ltsc_pkg::item_in_t    item,
	output ltsc_pkg::item_out_t   result
);
	import ltsc_pkg::*;

	logic [2:0]  fsm_q,   n_fsm;
	logic [31:0] tick_q,  n_tick;
	logic [31:0] light_q, n_light;
	logic [31:0] lock_q,  n_lock;
	logic [31:0] beep_q,  n_beep;
	logic [31:0] press_q, n_press;
	logic [31:0] blink_q, n_blink;
	logic [15:0] rbl_q,   n_rbl;
	logic [5:0]  flags_q, n_flags;
	logic [1:0]  pmode_q, n_pmode;
	logic        psw_q,   n_psw;
	logic        pbtn_q,  n_pbtn;
	logic [2:0]  led_q,   n_led;
	logic        run;

	// {turn on, turn off}
	function automatic logic [1:0] blink_act(input logic phase, input logic [31:0] elapsed,
		input logic [15:0] on_ms, input logic [15:0] off_ms);
		logic [1:0] act;
		act = 2'b00;
		if (!phase && elapsed >= {16'd0, off_ms})
			act = 2'b10;
		else if (phase && elapsed >= {16'd0, on_ms})
			act = 2'b01;
		return act;
	endfunction

	always_comb begin
		logic [31:0] now;
		logic        is_auto;
		logic        fell;
		logic        rose;
		logic [1:0]  act;

		n_fsm   = fsm_q;
		n_tick  = tick_q + 32'd1;
		n_light = light_q;
		n_lock  = lock_q;
		n_beep  = beep_q;
		n_press = press_q;
		n_blink = blink_q;
		n_rbl   = rbl_q;
		n_flags = flags_q;
		n_pmode = pmode_q;
		n_psw   = psw_q;
		n_pbtn  = pbtn_q;
		n_led   = led_q;
		run     = 1'b0;
		now     = tick_q;
		is_auto = (item.spray_mode != 2'd0);
		fell    = 1'b0;
		rose    = 1'b0;
		act     = 2'b00;

		if (rbl_q != 16'd0) begin
			n_rbl = rbl_q - 16'd1;
			if (n_rbl == 16'd0 && !psw_q) begin
				n_fsm              = ST_SPRAY;
				n_flags[F_SPRAYED] = 1'b1;
			end
		end else begin
			// selection change clears the session outside spray
			if ((n_flags[F_AUTO] != is_auto || n_pmode != item.spray_mode ||
			     n_psw != item.spray_after_off) && n_fsm != ST_SPRAY) begin
				n_light = '0;
				n_lock  = '0;
				n_beep  = '0;
				n_blink = '0;
				n_press = '0;
				n_flags = n_flags & (6'd1 << F_BTNSPRAY);
				n_flags[F_AUTO] = is_auto;
				n_fsm   = ST_IDLE;
				n_pmode = item.spray_mode;
				n_psw   = item.spray_after_off;
			end

			if (n_fsm != ST_SPRAY) begin
				fell   = !n_pbtn && item.button_down;
				rose   = n_pbtn && !item.button_down;
				n_pbtn = item.button_down;
				if (fell) begin
					n_flags[F_SPRAYED] = 1'b0;
					if (n_fsm == ST_BLOCKED) begin
						n_flags[F_HOLD] = 1'b1;
						n_press         = now;
					end else if (n_fsm == ST_READY && is_auto) begin
						n_flags[F_CANCEL] = 1'b1;
						n_flags[F_BLINK]  = 1'b0;
						n_fsm             = ST_WAIT;
						n_light           = now;
					end else begin
						n_fsm               = ST_SPRAY;
						n_flags[F_HOLD]     = 1'b0;
						n_flags[F_BTNSPRAY] = 1'b1;
					end
				end
				if (rose)
					n_flags[F_HOLD] = 1'b0;
			end

			priority if (n_fsm == ST_BEEP) begin
				if (now - n_beep >= {16'd0, cfg.reset_beep_ms})
					n_fsm = ST_IDLE;
			end else if (n_fsm == ST_SPRAY) begin
				run   = 1'b1;
				n_led = LED_G;
				if (item.spray_finished) begin
					n_led = LED_OFF;
					if (n_flags[F_BTNSPRAY]) begin
						n_light = '0;
						n_lock  = '0;
						n_beep  = '0;
						n_blink = '0;
						n_press = '0;
						n_flags = n_flags & (6'd1 << F_BTNSPRAY);
						n_flags[F_BTNSPRAY] = 1'b0;
						n_fsm   = ST_IDLE;
					end else begin
						n_lock = now;
						n_fsm  = ST_BLOCKED;
					end
				end
			end else if (n_fsm == ST_BLOCKED) begin
				if (item.light_present) begin
					act = blink_act(n_flags[F_BLINK], now - n_blink,
						cfg.blink_on_ms, cfg.blink_off_ms);
					if (act[1]) begin
						n_flags[F_BLINK] = 1'b1;
						n_blink          = now;
						n_led            = LED_R;
					end else if (act[0]) begin
						n_flags[F_BLINK] = 1'b0;
						n_blink          = now;
						n_led            = LED_OFF;
					end
				end else begin
					n_led = LED_OFF;
				end
				if (now - n_lock >= {8'd0, cfg.lockout_ms}) begin
					n_fsm = ST_IDLE;
					n_led = LED_OFF;
				end else if (n_flags[F_HOLD] &&
				             now - n_press >= {16'd0, cfg.reset_hold_ms}) begin
					n_fsm           = ST_BEEP;
					n_beep          = now;
					n_flags[F_HOLD] = 1'b0;
					n_led           = LED_OFF;
				end
			end else if (!item.light_present) begin
				n_flags[F_SPRAYED] = 1'b0;
				n_flags[F_CANCEL]  = 1'b0;
				n_flags[F_BLINK]   = 1'b0;
				n_fsm = (n_psw && n_fsm == ST_READY) ? ST_SPRAY : ST_IDLE;
				n_led = LED_OFF;
			end else if (n_fsm == ST_IDLE) begin
				n_light          = now;
				n_flags[F_BLINK] = 1'b0;
				n_fsm            = ST_WAIT;
			end else if (n_fsm == ST_WAIT) begin
				if (now - n_light < {16'd0, cfg.ready_wait_ms}) begin
					act = blink_act(n_flags[F_BLINK], now - n_blink,
						cfg.blink_on_ms, cfg.blink_off_ms);
					if (act[1]) begin
						n_flags[F_BLINK] = 1'b1;
						n_blink          = now;
						n_led            = LED_B;
					end else if (act[0]) begin
						n_flags[F_BLINK] = 1'b0;
						n_blink          = now;
						n_led            = LED_OFF;
					end
				end else if (!n_flags[F_CANCEL] && !n_flags[F_SPRAYED] && is_auto) begin
					n_fsm = ST_READY;
					n_led = LED_B;
					n_rbl = cfg.ready_tone_ms;
					if (cfg.ready_tone_ms == 16'd0 && !n_psw) begin
						n_fsm              = ST_SPRAY;
						n_flags[F_SPRAYED] = 1'b1;
					end
				end else begin
					n_light = now;
				end
			end else if (n_fsm == ST_READY) begin
				n_led = LED_B;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q   <= ST_IDLE;
			tick_q  <= '0;
			light_q <= '0;
			lock_q  <= '0;
			beep_q  <= '0;
			press_q <= '0;
			blink_q <= '0;
			rbl_q   <= '0;
			flags_q <= '0;
			pmode_q <= '0;
			psw_q   <= 1'b0;
			pbtn_q  <= 1'b0;
			led_q   <= LED_OFF;
		end else if (item_en) begin
			fsm_q   <= n_fsm;
			tick_q  <= n_tick;
			light_q <= n_light;
			lock_q  <= n_lock;
			beep_q  <= n_beep;
			press_q <= n_press;
			blink_q <= n_blink;
			rbl_q   <= n_rbl;
			flags_q <= n_flags;
			pmode_q <= n_pmode;
			psw_q   <= n_psw;
			pbtn_q  <= n_pbtn;
			led_q   <= n_led;
		end
	end

	always_comb begin
		result.fsm_state = n_fsm;
		result.led_red   = n_led[0];
		result.led_green = n_led[1];
		result.led_blue  = n_led[2];
		result.buzzer_on = (n_fsm == ST_BEEP) || (n_rbl != 16'd0);
		result.spray_run = run;
	end

endmodule

// ----- rtl/core/light_triggered_spray_controller.sv -----
// ----------------------------------------------------------------------------
// light_triggered_spray_controller
// Light triggered spray controller, one item per millisecond tick.
// ----------------------------------------------------------------------------
//  channel   dir  signals                                    item
//  s_axis    in   s_tvalid s_tready s_tdata[7:0]             one tick of inputs
//  m_axis    out  m_tvalid m_tready m_tdata[7:0]             one result per tick
//  cfg       in   cfg_valid cfg_ready cfg_index cfg_data     timing register write
//
// One item per cycle sustained while m_tready accepts results; an item sits in the
// input register, where the control state is updated, then sits in the result register.
// m_tvalid rises once the item advances from the input register into the result register.
// arst_n returns all timers, flags and timing registers to their reset values.
// A stalled result register holds the input register; while the result waits
// the input side takes at most one more item, then drops s_tready.
// ----------------------------------------------------------------------------
module light_triggered_spray_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [1:0] spray_mode, [2] light_present, [3] spray_after_off,
	// [4] button_down, [5] spray_finished, [7:6] unused
	input  logic [7:0]                      s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [2:0] fsm_state, [3] led_red, [4] led_green, [5] led_blue,
	// [6] buzzer_on, [7] spray_run
	output logic [7:0]                      m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ltsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [23:0]                     cfg_data
);
	import ltsc_pkg::*;

	cfg_t      cfg;
	logic      valid_s1;
	item_in_t  item_s1;
	logic      advance;
	item_out_t result;
	logic      out_valid_q;
	item_out_t out_data_q;

	assign cfg_ready = 1'b1;

	ltsc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in_t'(s_tdata[5:0]);
		end
	end

	ltsc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item_en (advance),
		.item    (item_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
